>>> rtl/core/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam logic [15:0] LimitReset  = 16'd10240;

  // Result kind carried on tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_t;

  // Register indexes on the configuration port
  localparam logic REG_SIZE_LIMIT    = 1'b0;
  localparam logic REG_COMMAND_LIMIT = 1'b1;

endpackage

>>> rtl/core/length_prefixed_deframer_unit.sv
// Length-prefixed message deframer: header parse, limit checks and payload pass-through.

// The block takes one received byte per beat and parses packets that open with a
// 4-byte header: total size then command, each 16 bits little-endian, the size
// counting the header. Header bytes give no result. A size below 4 or above
// size_limit, or a command above command_limit, gives one malformed result
// (tuser = 2) and the block then drops every byte until reset. A valid header of
// size 4 gives one empty-packet result (tuser = 1, tlast = 1). Otherwise each
// payload byte is passed on (tuser = 0) with the command and payload length, and
// the final one carries tlast. Throughput is one byte per clock cycle while the
// sink keeps taking results: the parser state and the single output register
// update in the same cycle, and a byte is taken whenever the output register is
// empty or being drained. An accepted byte's result is registered and appears on
// the output in the next cycle. The user must write configuration registers only
// while the stream is idle (not enforced); no clearing pass is needed after reset.
module length_prefixed_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,        // [7:0] data_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,       // [7:0] byte_value, [23:8] command_code,
                                       // [39:24] payload_length
  output logic [1:0]  out_tuser,       // [1:0] kind
  output logic        out_tlast,       // last
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [15:0] size_limit_r;
  logic [15:0] command_limit_r;

  // parser state
  logic [23:0] header_store_r, header_store_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic        in_payload_r, in_payload_nxt;
  logic [15:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [15:0] held_command_r, held_command_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic        closed_r, closed_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  lpd_pkg::kind_t      out_kind_r, out_kind_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [15:0]         out_cmd_r, out_cmd_nxt;
  logic [15:0]         out_len_r, out_len_nxt;
  logic                out_last_r, out_last_nxt;

  logic        in_beat;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] hdr_size;
  logic [15:0] hdr_cmd;
  logic        hdr_bad;

  // --- configuration port -------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // word address selects the register; byte offset bits are ignored
  assign cfg_index  = cfg_paddr[2];

  always_comb begin
    case (cfg_index)
      lpd_pkg::REG_SIZE_LIMIT:    cfg_prdata = {16'd0, size_limit_r};
      lpd_pkg::REG_COMMAND_LIMIT: cfg_prdata = {16'd0, command_limit_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r    <= lpd_pkg::LimitReset;
      command_limit_r <= lpd_pkg::LimitReset;
    end else if (cfg_write) begin
      if (cfg_index == lpd_pkg::REG_SIZE_LIMIT) begin
        size_limit_r <= cfg_pwdata[15:0];
      end else begin
        command_limit_r <= cfg_pwdata[15:0];
      end
    end
  end

  // --- handshake ------------------------------------------------------------
  // Take a byte whenever the output register is free or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  // --- header decode on the fourth byte -------------------------------------
  assign hdr_size = header_store_r[15:0];
  assign hdr_cmd  = {in_tdata, header_store_r[23:16]};
  assign hdr_bad  = (hdr_size < 16'(lpd_pkg::HeaderBytes)) || (hdr_size > size_limit_r) ||
                    (hdr_cmd > command_limit_r);

  always_comb begin
    header_store_nxt    = header_store_r;
    header_count_nxt    = header_count_r;
    in_payload_nxt      = in_payload_r;
    bytes_remaining_nxt = bytes_remaining_r;
    held_command_nxt    = held_command_r;
    held_length_nxt     = held_length_r;
    closed_nxt          = closed_r;

    // drain the output register when the sink takes it
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_cmd_nxt   = out_cmd_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;

    if (in_beat && !closed_r) begin
      if (in_payload_r) begin
        // pass the payload byte on, mark the final one
        out_valid_nxt       = 1'b1;
        out_kind_nxt        = lpd_pkg::KIND_PAYLOAD;
        out_byte_nxt        = in_tdata;
        out_cmd_nxt         = held_command_r;
        out_len_nxt         = held_length_r;
        out_last_nxt        = (bytes_remaining_r == 16'd1);
        bytes_remaining_nxt = bytes_remaining_r - 16'd1;
        if (bytes_remaining_r == 16'd1) begin
          in_payload_nxt = 1'b0;
        end
      end else if (header_count_r != 2'(lpd_pkg::HeaderBytes - 1)) begin
        // gather one of the first three header bytes
        case (header_count_r)
          2'd0:    header_store_nxt[7:0]   = in_tdata;
          2'd1:    header_store_nxt[15:8]  = in_tdata;
          default: header_store_nxt[23:16] = in_tdata;
        endcase
        header_count_nxt = header_count_r + 2'd1;
      end else begin
        header_store_nxt = 24'd0;
        header_count_nxt = 2'd0;
        out_cmd_nxt      = hdr_cmd;
        out_byte_nxt     = 8'd0;
        out_len_nxt      = 16'd0;
        if (hdr_bad) begin
          // report once, then drop everything until reset
          closed_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = lpd_pkg::KIND_MALFORMED;
          out_last_nxt  = 1'b0;
        end else begin
          held_command_nxt = hdr_cmd;
          held_length_nxt  = hdr_size - 16'(lpd_pkg::HeaderBytes);
          if (hdr_size == 16'(lpd_pkg::HeaderBytes)) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = lpd_pkg::KIND_EMPTY;
            out_last_nxt  = 1'b1;
          end else begin
            bytes_remaining_nxt = hdr_size - 16'(lpd_pkg::HeaderBytes);
            in_payload_nxt      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_store_r    <= 24'd0;
      header_count_r    <= 2'd0;
      in_payload_r      <= 1'b0;
      bytes_remaining_r <= 16'd0;
      held_command_r    <= 16'd0;
      held_length_r     <= 16'd0;
      closed_r          <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      header_store_r    <= header_store_nxt;
      header_count_r    <= header_count_nxt;
      in_payload_r      <= in_payload_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      held_command_r    <= held_command_nxt;
      held_length_r     <= held_length_nxt;
      closed_r          <= closed_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // payload of the output register needs no reset
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_cmd_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // --- assertions -------------------------------------------------------------
  // A byte taken while closed never produces a result.
  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && closed_r |=> !out_tvalid)
    else $error("result produced while closed");

  // A malformed result being delivered means the parser has closed.
  a_malformed_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lpd_pkg::KIND_MALFORMED |-> closed_r)
    else $error("malformed result without closing");

  // Payload phase and header gathering never overlap, and payload never runs dry.
  a_payload_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> header_count_r == 2'd0 && bytes_remaining_r != 16'd0)
    else $error("inconsistent payload state");

  // The last payload byte leaves the payload phase.
  a_last_ends_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_payload_r && !closed_r && bytes_remaining_r == 16'd1 |=> !in_payload_r)
    else $error("payload phase overran its length");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed deframer unit.
module tb_top;

  localparam int unsigned MaxMismatchLines    = 40;
  localparam int unsigned DrainCycles         = 5000;
  localparam int unsigned SettleCycles        = 4;     // room for the registered output, plus margin
  localparam int unsigned RandomBytesPerPhase = 150;
  localparam int unsigned NumPhases           = 8;
  localparam int unsigned NoiseBytes          = 40;

  // One result beat as it should appear on the result stream
  typedef struct packed {
    lpd_pkg::kind_t kind;
    logic [7:0]     byte_value;
    logic [15:0]    command_code;
    logic [15:0]    payload_length;
    logic           last;
  } deframed_beat_t;

  // How a directed row is checked: typed "no beat", typed beat, or predicted
  typedef enum logic [1:0] {
    CHK_SILENT,
    CHK_TYPED,
    CHK_PREDICT
  } row_check_t;

  typedef struct {
    logic [7:0]     data;
    row_check_t     check;
    deframed_beat_t beat;
  } stim_row_t;

  // Which side idles or stalls during a phase
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // What breaks the closing header; closing is permanent, so it runs last
  typedef enum logic [1:0] {
    BAD_SIZE_LOW,
    BAD_SIZE_HIGH,
    BAD_COMMAND,
    BAD_SIZE_LIMIT
  } close_cause_t;

  localparam deframed_beat_t NoBeat = '0;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;   // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;             // [7:0] byte_value, [23:8] command_code,
                                      // [39:24] payload_length
  logic [1:0]  out_tuser;             // [1:0] kind
  logic        out_tlast;             // last
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = 3'd0;
  logic [31:0] cfg_pwdata  = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #5 clk = ~clk;

  length_prefixed_deframer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Deframer predictor: our own copy of the limits and the parse state
  // ---------------------------------------------------------------------------
  logic [15:0] max_size      = lpd_pkg::LimitReset;
  logic [15:0] max_cmd       = lpd_pkg::LimitReset;
  logic [23:0] hdr_bytes     = '0;   // size low, size high, command low
  logic [1:0]  hdr_count     = '0;
  logic        in_body       = 1'b0;
  logic [15:0] body_left     = '0;
  logic [15:0] pkt_cmd       = '0;
  logic [15:0] pkt_len       = '0;
  logic        stream_closed = 1'b0;

  deframed_beat_t pending_beats[$];   // beats still owed by the block, oldest first
  int unsigned    mismatch_count = 0;
  idle_mode_t     idle_mode = IDLE_NONE;

  // Advance the parse by one received byte; return 1 when it yields a beat.
  function automatic bit deframe_byte(input logic [7:0] b, output deframed_beat_t beat);
    logic [15:0] size;
    logic [15:0] cmd;
    beat = NoBeat;
    // a malformed header shuts the stream until reset
    if (stream_closed) return 1'b0;
    if (in_body) begin
      beat = '{lpd_pkg::KIND_PAYLOAD, b, pkt_cmd, pkt_len, body_left == 16'd1};
      body_left = body_left - 16'd1;
      if (body_left == 16'd0) in_body = 1'b0;
      return 1'b1;
    end
    // gather the first three header bytes silently
    if (hdr_count != 2'(lpd_pkg::HeaderBytes - 1)) begin
      hdr_bytes[8*hdr_count +: 8] = b;
      hdr_count = hdr_count + 2'd1;
      return 1'b0;
    end
    size      = hdr_bytes[15:0];
    cmd       = {b, hdr_bytes[23:16]};
    hdr_bytes = '0;
    hdr_count = '0;
    // a size limit below four makes every header fail here
    if (size < 16'(lpd_pkg::HeaderBytes) || size > max_size || cmd > max_cmd) begin
      stream_closed = 1'b1;
      beat = '{lpd_pkg::KIND_MALFORMED, 8'h00, cmd, 16'h0000, 1'b0};
      return 1'b1;
    end
    pkt_cmd = cmd;
    pkt_len = size - 16'(lpd_pkg::HeaderBytes);
    if (pkt_len == 16'd0) begin
      beat = '{lpd_pkg::KIND_EMPTY, 8'h00, cmd, 16'h0000, 1'b1};
      return 1'b1;
    end
    body_left = pkt_len;
    in_body   = 1'b1;
    return 1'b0;
  endfunction

  // Roll the idle dice for one side under the current phase's mode.
  function automatic bit stall_now(input bit is_sender);
    int unsigned pct;
    case (idle_mode)
      IDLE_SENDER:   pct = is_sender ? 69 : 0;
      IDLE_RECEIVER: pct = is_sender ? 0 : 69;
      IDLE_BOTH:     pct = 12;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxMismatchLines) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the in-order checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= !stall_now(1'b0);
  end

  // Compare every accepted result beat with the oldest predicted one.
  always @(posedge clk) begin : check_results
    deframed_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tuser=%0d tdata=%h tlast=%b",
                                  out_tuser, out_tdata, out_tlast));
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
        if (out_tdata[7:0] !== want.byte_value)
          report_mismatch($sformatf("byte_value %h, want %h", out_tdata[7:0], want.byte_value));
        if (out_tdata[23:8] !== want.command_code)
          report_mismatch($sformatf("command_code %h, want %h", out_tdata[23:8],
                                    want.command_code));
        if (out_tdata[39:24] !== want.payload_length)
          report_mismatch($sformatf("payload_length %0d, want %0d", out_tdata[39:24],
                                    want.payload_length));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one byte, idling first at random; predict once the beat is taken.
  // Entered right after a rising edge, so each signal gets one update per step.
  task automatic push_byte(input logic [7:0] b, output bit got, output deframed_beat_t beat);
    while (stall_now(1'b1)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    got = deframe_byte(b, beat);
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit             got;
    deframed_beat_t beat;
    push_byte(b, got, beat);
    if (got) pending_beats.insert(pending_beats.size(), beat);
  endtask

  // Send a header, size then command, little-endian, and a random payload.
  task automatic send_frame(input logic [15:0] size, input logic [15:0] cmd,
                            input int unsigned pay_bytes);
    send_byte(size[7:0]);
    send_byte(size[15:8]);
    send_byte(cmd[7:0]);
    send_byte(cmd[15:8]);
    repeat (pay_bytes) send_byte(8'($urandom));
  endtask

  // Hold the sender until every owed beat has come, then let the block settle.
  task automatic wait_for_results();
    int unsigned n = 0;
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0 && n < DrainCycles) begin
      @(posedge clk);
      n++;
    end
    if (pending_beats.size() != 0) begin
      report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));
      pending_beats.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  // Read a register back and compare; ends the transfer by dropping select and enable.
  task automatic cfg_check(input logic reg_idx, input logic [15:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'h0000, want})
      report_mismatch($sformatf("register %0d reads %h, want %h", reg_idx, cfg_prdata, want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register (junk in the unused upper bits), then read it back.
  task automatic cfg_write(input logic reg_idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == lpd_pkg::REG_SIZE_LIMIT) max_size = value;
    else max_cmd = value;
    cfg_check(reg_idx, value);
  endtask

  // ---------------------------------------------------------------------------
  // Directed opening, run at the reset limits. Typed rows are read straight
  // off the framing rules; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [25] = '{
    // empty packet, command zero
    '{8'h04, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h00, CHK_TYPED,  '{lpd_pkg::KIND_EMPTY, 8'h00, 16'h0000, 16'h0000, 1'b1}},
    // one all-ones payload byte, command right at the limit
    '{8'h05, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h28, CHK_SILENT, NoBeat},
    '{8'hFF, CHK_TYPED,  '{lpd_pkg::KIND_PAYLOAD, 8'hFF, 16'h2800, 16'h0001, 1'b1}},
    // three payload bytes
    '{8'h07, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h34, CHK_SILENT, NoBeat},
    '{8'h12, CHK_SILENT, NoBeat},
    '{8'h00, CHK_PREDICT, NoBeat},
    '{8'h5A, CHK_PREDICT, NoBeat},
    '{8'h80, CHK_PREDICT, NoBeat},
    // one payload byte, small command
    '{8'h05, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'hAB, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h7F, CHK_PREDICT, NoBeat},
    // empty packet at the command limit
    '{8'h04, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h00, CHK_SILENT, NoBeat},
    '{8'h28, CHK_TYPED,  '{lpd_pkg::KIND_EMPTY, 8'h00, 16'h2800, 16'h0000, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    deframed_beat_t beat;
    bit             got;
    int unsigned    sent;
    int unsigned    pay_len;
    int unsigned    max_pay;
    int unsigned    r;
    logic [15:0]    size_val;
    logic [15:0]    cmd_val;
    logic [15:0]    new_size;
    logic [15:0]    new_cmd;
    close_cause_t   cause;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limits come up at their reset value
    cfg_check(lpd_pkg::REG_SIZE_LIMIT, lpd_pkg::LimitReset);
    cfg_check(lpd_pkg::REG_COMMAND_LIMIT, lpd_pkg::LimitReset);

    foreach (directed_rows[i]) begin
      push_byte(directed_rows[i].data, got, beat);
      case (directed_rows[i].check)
        CHK_TYPED:   pending_beats.insert(pending_beats.size(), directed_rows[i].beat);
        CHK_PREDICT: if (got) pending_beats.insert(pending_beats.size(), beat);
        default:     ;
      endcase
    end

    // Random phases: well-formed packets with random content under a range of
    // limits, including both extremes of each register. Each phase rotates the
    // idle pattern so gaps land on header, payload and empty-packet beats.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        case (ph)
          1:       begin new_size = 16'd4;     new_cmd = 16'd0;     end
          2:       begin new_size = 16'hFFFF;  new_cmd = 16'hFFFF;  end
          3:       begin new_size = 16'($urandom_range(5, 40));
                         new_cmd  = 16'($urandom);                  end
          4:       begin new_size = 16'hFFFF;  new_cmd = 16'd0;     end
          5:       begin new_size = 16'd4;     new_cmd = 16'hFFFF;  end
          6:       begin new_size = 16'($urandom_range(4, 600));
                         new_cmd  = 16'($urandom);                  end
          default: begin new_size = lpd_pkg::LimitReset;
                         new_cmd  = lpd_pkg::LimitReset;            end
        endcase
        // limits change only with the stream drained
        wait_for_results();
        cfg_write(lpd_pkg::REG_SIZE_LIMIT, new_size);
        cfg_write(lpd_pkg::REG_COMMAND_LIMIT, new_cmd);
      end
      idle_mode = idle_mode_t'(ph % 4);
      sent = 0;
      while (sent < RandomBytesPerPhase) begin
        // mostly short payloads, some empty, a few long or right at the limit
        max_pay = max_size - 16'(lpd_pkg::HeaderBytes);
        r = $urandom_range(0, 99);
        if (max_pay == 0 || r < 10)      pay_len = 0;
        else if (r < 15 && max_pay <= 300) pay_len = max_pay;
        else if (r < 85) pay_len = $urandom_range(1, (max_pay < 16)  ? max_pay : 16);
        else if (r < 97) pay_len = $urandom_range(1, (max_pay < 64)  ? max_pay : 64);
        else             pay_len = $urandom_range(1, (max_pay < 300) ? max_pay : 300);
        // command: often zero or the limit itself
        r = $urandom_range(0, 3);
        if (r == 0)      cmd_val = 16'd0;
        else if (r == 1) cmd_val = max_cmd;
        else             cmd_val = 16'($urandom_range(0, max_cmd));
        send_frame(16'(pay_len + lpd_pkg::HeaderBytes), cmd_val, pay_len);
        sent += pay_len + lpd_pkg::HeaderBytes;
        // now and then hold the sender until the block has caught up
        if ($urandom_range(0, 24) == 0) wait_for_results();
      end
    end

    // Closing: one malformed header, then noise that must all be dropped.
    // The block stays closed until reset, so this can only happen once.
    wait_for_results();
    idle_mode = idle_mode_t'($urandom_range(0, 3));
    cause     = close_cause_t'($urandom_range(0, 3));
    size_val  = 16'($urandom_range(4, 64));
    cmd_val   = 16'($urandom_range(0, max_cmd));
    case (cause)
      BAD_SIZE_LOW:  size_val = 16'($urandom_range(0, 3));
      BAD_SIZE_HIGH: size_val = 16'($urandom_range(max_size + 1, 16'hFFFF));
      BAD_COMMAND:   cmd_val  = 16'($urandom_range(max_cmd + 1, 16'hFFFF));
      default: begin
        // a size limit under four rejects any header at all
        cfg_write(lpd_pkg::REG_SIZE_LIMIT, 16'($urandom_range(0, 3)));
        size_val = 16'($urandom);
      end
    endcase
    send_frame(size_val, cmd_val, 0);
    repeat (NoiseBytes) send_byte(8'($urandom));
    wait_for_results();

    if (mismatch_count == 0) begin
      $display("** length_prefixed_deframer_unit: PASSED **");
    end else begin
      $display("** length_prefixed_deframer_unit: FAILED **");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("** length_prefixed_deframer_unit: FAILED **");
    $finish;
  end

endmodule
